/* sv/alst_pkg.sv */
// ----------------------------------------------------------------------------
// alst_pkg
// Shared constants, codes and control types of the array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package alst_pkg;

	localparam int CAPACITY = 128;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// common width for comparing the 7-bit index field against the count
	localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;

	// request codes
	localparam logic [2:0] OP_APPEND   = 3'd0;
	localparam logic [2:0] OP_DEL_LAST = 3'd1;
	localparam logic [2:0] OP_DEL_AT   = 3'd2;
	localparam logic [2:0] OP_SEARCH   = 3'd3;
	localparam logic [2:0] OP_DEL_EQ   = 3'd4;
	localparam logic [2:0] OP_READ     = 3'd5;
	localparam logic [2:0] OP_CLEAR    = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SWEEP,
		S_FIN
	} alst_state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch the request
		logic exec;      // single-cycle part of the operation
		logic step;      // one memory sweep cycle
		logic commit;    // final count/status update after a sweep
		logic load_out;  // load the output register
	} alst_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic needs_sweep;
		logic sweep_done;
		logic out_free;
	} alst_sts_t;

endpackage

`default_nettype wire

/* sv/array_list_engine_top.sv */
// ----------------------------------------------------------------------------
// array_list_engine_top
// Bounded list of signed 32-bit entries with append, delete, search,
// delete-all-equal with compaction, read and clear.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests come in on the s_ channel; one result item per request leaves
//    on the m_ channel, in request order.
//  - s_tready is high only while the engine is idle; one request is worked
//    on at a time.
//  - Append, delete last, read, clear and requests that fail their checks need
//    no sweep. Search, delete at index and delete all equal sweep the entry
//    memory one entry per cycle through its single registered read port,
//    walking at most CAPACITY entries. Search stops at the first match.
//  - The result sits in an output register, so a new request is taken while
//    the previous result still waits for m_tready; a stalled receiver only
//    holds the engine once the next result is ready to be loaded.
//  - Reset empties the list (count 0) and drops any pending result. Memory
//    contents are not cleared; entries at or above the count are never read.
//  - Request code 7 is ignored and reports ok with the count unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // value[31:0], index[38:32], zero pad[39]
	input  wire logic [2:0]  s_tuser,   // req_type[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // found_index[6:0], read_value[38:7],
	                                    // entry_count[46:39], zero pad[47]
	output logic [2:0]       m_tuser    // status[2:0]
);
	import alst_pkg::*;

	alst_cmd_t          cmd;
	alst_sts_t          sts;
	logic [2:0]         status;
	logic [6:0]         found_index;
	logic signed [31:0] read_value;
	logic [7:0]         entry_count;

	alst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	alst_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (s_tuser),
		.value       (s_tdata[31:0]),
		.index       (s_tdata[38:32]),
		.cmd         (cmd),
		.sts         (sts),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.status      (status),
		.found_index (found_index),
		.read_value  (read_value),
		.entry_count (entry_count)
	);

	assign m_tdata = {1'b0, entry_count, read_value, found_index};
	assign m_tuser = status;

endmodule

`default_nettype wire

/* sv/alst_ctrl.sv */
// ----------------------------------------------------------------------------
// alst_ctrl
// Sequencer: accept, execute, optional memory sweep, deliver result.
// ----------------------------------------------------------------------------
`default_nettype none

module alst_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire alst_pkg::alst_sts_t sts,
	output alst_pkg::alst_cmd_t   cmd
);
	import alst_pkg::*;

	alst_state_t state_q;
	alst_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = sts.needs_sweep ? S_SWEEP : S_FIN;
			end
			S_SWEEP: begin
				if (sts.sweep_done) state_nxt = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_SWEEP: begin
				cmd.step   = 1'b1;
				cmd.commit = sts.sweep_done;
			end
			S_FIN: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/alst_datapath.sv */
// ----------------------------------------------------------------------------
// alst_datapath
// Entry memory, count, sweep pointers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module alst_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [2:0]          req_type,
	input  wire logic signed [31:0]  value,
	input  wire logic [6:0]          index,
	input  wire alst_pkg::alst_cmd_t cmd,
	output alst_pkg::alst_sts_t      sts,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [2:0]               status,
	output logic [6:0]               found_index,
	output logic signed [31:0]       read_value,
	output logic [7:0]               entry_count
);
	import alst_pkg::*;

	localparam int FEXT_W = (ADDR_W > 7) ? ADDR_W : 7;
	localparam int CEXT_W = (CNT_W > 8) ? CNT_W : 8;

	// entry memory
	logic [31:0]       mem [CAPACITY];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [31:0]       mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [31:0]       rdata_s1;

	// request
	logic [2:0]        op_q;
	logic [31:0]       val_q;
	logic [6:0]        idx_q;

	// list and sweep state
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rptr_q;
	logic [CNT_W-1:0]  wptr_q;
	logic              rvld_s1;
	logic [ADDR_W-1:0] raddr_s1;
	logic              hit_q;
	logic [2:0]        stat_q;
	logic [ADDR_W-1:0] found_q;

	// output register
	logic              out_vld_q;
	logic [2:0]        out_stat_q;
	logic [6:0]        out_found_q;
	logic [31:0]       out_rd_q;
	logic [7:0]        out_cnt_q;

	logic [CMP_W-1:0]  idx_ext;
	logic [CMP_W-1:0]  cnt_cmp;
	logic              is_empty;
	logic              is_full;
	logic              idx_range;
	logic              issue_ok;
	logic              keep;
	logic              wr_keep;
	logic              hit_now;
	logic [FEXT_W-1:0] found_ext;
	logic [CEXT_W-1:0] cnt_ext;

	assign idx_ext   = CMP_W'(idx_q);
	assign cnt_cmp   = CMP_W'(cnt_q);
	assign is_empty  = (cnt_q == '0);
	assign is_full   = (cnt_q >= CNT_W'(CAPACITY));
	assign idx_range = (idx_ext >= cnt_cmp);

	// sweep keeps reading while entries remain, search stops on first hit
	assign issue_ok  = (rptr_q < cnt_q) && !((op_q == OP_SEARCH) && hit_q);
	assign keep      = (op_q == OP_DEL_AT) ? (CMP_W'(raddr_s1) != idx_ext)
	                                      : (rdata_s1 != val_q);
	assign wr_keep   = cmd.step && rvld_s1 && (op_q != OP_SEARCH) && keep;
	assign hit_now   = cmd.step && rvld_s1 && (op_q == OP_SEARCH) && !hit_q &&
	                   (rdata_s1 == val_q);

	assign sts.needs_sweep = !is_empty && (((op_q == OP_DEL_AT) && !idx_range) ||
	                         (op_q == OP_SEARCH) || (op_q == OP_DEL_EQ));
	assign sts.sweep_done  = !issue_ok && !rvld_s1;
	assign sts.out_free    = !out_vld_q || m_tready;

	// memory port muxing: append in exec, compaction writes during sweep
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wptr_q[ADDR_W-1:0];
		mem_wdata = rdata_s1;
		if (cmd.exec && (op_q == OP_APPEND) && !is_full) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q[ADDR_W-1:0];
			mem_wdata = val_q;
		end else if (wr_keep) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = rptr_q[ADDR_W-1:0];
		if (cmd.exec && (op_q == OP_READ) && !idx_range) begin
			mem_re    = 1'b1;
			mem_raddr = idx_ext[ADDR_W-1:0];
		end else if (cmd.step && issue_ok) begin
			mem_re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_s1 <= mem[mem_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rvld_s1   <= 1'b0;
			hit_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				rvld_s1 <= 1'b0;
				hit_q   <= 1'b0;
				case (op_q)
					OP_APPEND:   if (!is_full) cnt_q <= cnt_q + 1'b1;
					OP_DEL_LAST: if (!is_empty) cnt_q <= cnt_q - 1'b1;
					OP_CLEAR:    cnt_q <= '0;
					default:     cnt_q <= cnt_q;
				endcase
			end
			if (cmd.step) begin
				rvld_s1 <= issue_ok;
				if (hit_now) hit_q <= 1'b1;
			end
			if (cmd.commit) begin
				if (op_q == OP_DEL_AT) cnt_q <= cnt_q - 1'b1;
				else if (op_q == OP_DEL_EQ) cnt_q <= wptr_q;
			end
			if (cmd.load_out) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= req_type;
			val_q <= value;
			idx_q <= index;
		end
		if (cmd.exec) begin
			found_q <= '0;
			if (op_q == OP_DEL_AT) begin
				rptr_q <= idx_ext[CNT_W-1:0];
				wptr_q <= idx_ext[CNT_W-1:0];
			end else begin
				rptr_q <= '0;
				wptr_q <= '0;
			end
			case (op_q)
				OP_APPEND:   stat_q <= is_full ? ST_FULL : ST_OK;
				OP_DEL_LAST: stat_q <= is_empty ? ST_EMPTY : ST_OK;
				OP_DEL_AT:   stat_q <= is_empty ? ST_EMPTY : (idx_range ? ST_RANGE : ST_OK);
				OP_SEARCH:   stat_q <= ST_NOTFOUND;
				OP_DEL_EQ:   stat_q <= ST_NOTFOUND;
				OP_READ:     stat_q <= idx_range ? ST_RANGE : ST_OK;
				default:     stat_q <= ST_OK;
			endcase
		end
		if (cmd.step) begin
			if (issue_ok) begin
				rptr_q   <= rptr_q + 1'b1;
				raddr_s1 <= rptr_q[ADDR_W-1:0];
			end
			if (hit_now) begin
				found_q <= raddr_s1;
				stat_q  <= ST_OK;
			end
			if (wr_keep) wptr_q <= wptr_q + 1'b1;
		end
		if (cmd.commit && (op_q == OP_DEL_EQ)) begin
			stat_q <= (wptr_q == cnt_q) ? ST_NOTFOUND : ST_OK;
		end
		if (cmd.load_out) begin
			out_stat_q  <= stat_q;
			out_found_q <= found_ext[6:0];
			out_rd_q    <= ((op_q == OP_READ) && (stat_q == ST_OK)) ? rdata_s1 : 32'd0;
			out_cnt_q   <= cnt_ext[7:0];
		end
	end

	assign found_ext   = FEXT_W'(found_q);
	assign cnt_ext     = CEXT_W'(cnt_q);

	assign m_tvalid    = out_vld_q;
	assign status      = out_stat_q;
	assign found_index = out_found_q;
	assign read_value  = out_rd_q;
	assign entry_count = out_cnt_q;

endmodule

`default_nettype wire

/* sv/alst_checker.sv */
// ----------------------------------------------------------------------------
// alst_checker
// Port-level checks of the array list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module alst_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [2:0]  m_tuser
);
	import alst_pkg::*;

	// one request at a time: input closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while one is in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= ST_NOTFOUND))
		else $error("undefined status code");

	// failed operations report zero index and zero read value
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[38:0] == 39'd0))
		else $error("nonzero index or value on failed request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind array_list_engine_top alst_checker u_alst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

/* bench/array_list_engine_top_test.sv */
// ----------------------------------------------------------------------------
// array_list_engine_top_test
// Self-checking bench for the array list engine. A shadow copy of the list
// predicts status, found index, read value and count for every request;
// results are checked in order. Directed corner cases come first, then a
// fill to capacity, a long receiver hold-off, and a random mix of requests.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine_top_test;

	import alst_pkg::*;

	localparam logic [2:0] OP_UNUSED    = 3'd7;
	localparam int         HALF_PERIOD  = 6;
	localparam int         RANDOM_ITEMS = 640;
	localparam int         HOLD_CYCLES  = 400;
	localparam int         QUIET_LIMIT  = 4000;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  found_index;
		logic [31:0] read_value;
		logic [7:0]  entry_count;
	} list_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;

	// shadow list
	logic [31:0] shadow_entries [0:CAPACITY-1];
	int          shadow_count;
	int          peak_count;

	list_result_t pending_results[$];
	logic [31:0]  value_pool [0:5];

	int   errors = 0;
	int   results_seen = 0;
	int   requests_seen;
	int   op_seen [0:7];
	int   quiet_cycles = 0;
	logic calm;
	int   hold_reqs;
	int   holds_done;

	array_list_engine_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// applies one request to the shadow list and returns the expected result
	function automatic list_result_t list_apply(logic [2:0] op, logic [31:0] val,
			logic [6:0] idx);
		list_result_t r;
		int i;
		int w;
		logic hit;
		r = '0;
		case (op)
			OP_APPEND: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					shadow_entries[shadow_count] = val;
					shadow_count++;
				end
			end
			OP_DEL_LAST: begin
				if (shadow_count == 0) r.status = ST_EMPTY;
				else shadow_count--;
			end
			OP_DEL_AT: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else if (int'(idx) >= shadow_count) begin
					r.status = ST_RANGE;
				end else begin
					for (i = int'(idx); i + 1 < shadow_count; i++)
						shadow_entries[i] = shadow_entries[i + 1];
					shadow_count--;
				end
			end
			OP_SEARCH: begin
				r.status = ST_NOTFOUND;
				hit = 1'b0;
				for (i = 0; i < shadow_count; i++) begin
					if (!hit && shadow_entries[i] == val) begin
						hit = 1'b1;
						r.status = ST_OK;
						r.found_index = i[6:0];
					end
				end
			end
			OP_DEL_EQ: begin
				w = 0;
				for (i = 0; i < shadow_count; i++) begin
					if (shadow_entries[i] != val) begin
						shadow_entries[w] = shadow_entries[i];
						w++;
					end
				end
				if (w == shadow_count) r.status = ST_NOTFOUND;
				shadow_count = w;
			end
			OP_READ: begin
				if (int'(idx) >= shadow_count) r.status = ST_RANGE;
				else r.read_value = shadow_entries[idx];
			end
			OP_CLEAR: shadow_count = 0;
			default: ;
		endcase
		r.entry_count = shadow_count[7:0];
		return r;
	endfunction

	// often a small pool (so searches and deletes hit), sometimes a live entry
	function automatic logic [31:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45) return value_pool[$urandom_range(0, 5)];
		if (roll < 70 && shadow_count > 0)
			return shadow_entries[$urandom_range(0, shadow_count - 1)];
		return $urandom;
	endfunction

	function automatic logic [6:0] pick_index();
		if (shadow_count > 0 && $urandom_range(0, 99) < 75)
			return 7'($urandom_range(0, shadow_count - 1));
		return 7'($urandom_range(0, 127));
	endfunction

	// offers one item, returns once it is accepted and predicted
	task automatic send_item(logic [2:0] op, logic [31:0] val, logic [6:0] idx);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 36) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, idx, val};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(list_apply(op, val, idx));
		requests_seen++;
		op_seen[op]++;
		if (shadow_count > peak_count) peak_count = shadow_count;
	endtask

	task automatic test_empty_list();
		send_item(OP_DEL_LAST, 32'd0, 7'd0);
		send_item(OP_DEL_AT, 32'd0, 7'd0);
		send_item(OP_SEARCH, 32'd0, 7'd0);
		send_item(OP_DEL_EQ, 32'd0, 7'd0);
		send_item(OP_READ, 32'd0, 7'd127);
		send_item(OP_UNUSED, 32'hFFFF_FFFF, 7'd127);
	endtask

	task automatic test_basic_ops();
		send_item(OP_APPEND, 32'h8000_0000, 7'd0);
		send_item(OP_APPEND, 32'h7FFF_FFFF, 7'd127);
		send_item(OP_APPEND, 32'h0000_0000, 7'd0);
		send_item(OP_APPEND, 32'hFFFF_FFFF, 7'd0);
		send_item(OP_READ, 32'd0, 7'd0);
		send_item(OP_READ, 32'd0, 7'd3);
		send_item(OP_READ, 32'd0, 7'd4);           // just past the end
		send_item(OP_SEARCH, 32'h7FFF_FFFF, 7'd0);
		send_item(OP_SEARCH, 32'h1234_5678, 7'd0);  // no match
		send_item(OP_DEL_AT, 32'd0, 7'd9);          // out of range
		send_item(OP_DEL_AT, 32'd0, 7'd1);
		send_item(OP_DEL_LAST, 32'd0, 7'd0);
		send_item(OP_APPEND, 32'd5, 7'd0);
		send_item(OP_APPEND, 32'd5, 7'd0);
		send_item(OP_UNUSED, 32'd5, 7'd0);
		send_item(OP_DEL_EQ, 32'd5, 7'd0);          // adjacent matches
		send_item(OP_DEL_EQ, 32'd5, 7'd0);          // nothing left to remove
		send_item(OP_CLEAR, 32'd0, 7'd0);
	endtask

	task automatic test_fill_to_capacity();
		int i;
		send_item(OP_CLEAR, 32'd0, 7'd0);
		for (i = 0; i < CAPACITY; i++)
			send_item(OP_APPEND, ($urandom_range(0, 3) == 0) ? value_pool[0] : $urandom,
				7'd0);
		send_item(OP_APPEND, 32'hDEAD_BEEF, 7'd0);  // full
		send_item(OP_READ, 32'd0, 7'd127);
		send_item(OP_SEARCH, shadow_entries[CAPACITY - 1], 7'd0);
		send_item(OP_DEL_AT, 32'd0, 7'd0);          // longest shift
		send_item(OP_APPEND, value_pool[0], 7'd0);
		send_item(OP_DEL_EQ, value_pool[0], 7'd0);
		send_item(OP_DEL_LAST, 32'd0, 7'd0);
	endtask

	// receiver goes quiet for a long stretch while requests keep coming
	task automatic test_output_stall();
		int i;
		hold_reqs++;
		for (i = 0; i < 40; i++)
			send_item(($urandom_range(0, 1) == 0) ? OP_APPEND : OP_SEARCH, pick_value(),
				pick_index());
	endtask

	task automatic test_random_mix();
		int sent;
		int roll;
		int grow_bias;
		logic [2:0] op;
		sent = 0;
		grow_bias = 40;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 100 == 0) grow_bias = $urandom_range(10, 65);
			calm = (sent >= 300 && sent < 420);
			roll = $urandom_range(0, 99);
			if (roll < grow_bias) begin
				op = OP_APPEND;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 12) op = OP_DEL_LAST;
				else if (roll < 32) op = OP_DEL_AT;
				else if (roll < 55) op = OP_SEARCH;
				else if (roll < 72) op = OP_DEL_EQ;
				else if (roll < 96) op = OP_READ;
				else if (roll < 98) op = OP_CLEAR;
				else op = OP_UNUSED;
			end
			send_item(op, pick_value(), pick_index());
			if (op != OP_UNUSED) sent++;
		end
		calm = 1'b0;
	endtask

	// receiver side
	initial begin : receiver
		m_tready   = 1'b0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 36);
			end
		end
	end

	always @(posedge clk) begin : result_check
		list_result_t got;
		list_result_t want;
		if (m_tvalid && m_tready) begin
			got.status      = m_tuser;
			got.found_index = m_tdata[6:0];
			got.read_value  = m_tdata[38:7];
			got.entry_count = m_tdata[46:39];
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result item with no request pending");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					errors++;
				end
				if (got.found_index !== want.found_index) begin
					$error("found_index: expected %0d, actual %0d",
						want.found_index, got.found_index);
					errors++;
				end
				if (got.read_value !== want.read_value) begin
					$error("read_value: expected %0d, actual %0d",
						$signed(want.read_value), $signed(got.read_value));
					errors++;
				end
				if (got.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
						want.entry_count, got.entry_count);
					errors++;
				end
			end
		end
	end

	// ends the run if neither side moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("array_list_engine_top_test: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		calm          = 1'b0;
		hold_reqs     = 0;
		requests_seen = 0;
		shadow_count  = 0;
		peak_count    = 0;
		foreach (op_seen[i]) op_seen[i] = 0;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		value_pool[4] = 32'h0000_0001;
		value_pool[5] = 32'h0000_002A;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_basic_ops();
		test_fill_to_capacity();
		test_output_stall();
		test_random_mix();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);

		$display("covered %0d requests, %0d results, peak list length %0d of %0d",
			requests_seen, results_seen, peak_count, CAPACITY);
		$display("  app %0d, dl %0d, da %0d, srch %0d, deq %0d, rd %0d, clr %0d, unused %0d",
			op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
			op_seen[6], op_seen[7]);
		if (errors == 0) begin
			$display("array_list_engine_top_test: PASS");
		end else begin
			$display("array_list_engine_top_test: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* array_list_engine_top.f */
sv/alst_pkg.sv
sv/alst_ctrl.sv
sv/alst_datapath.sv
sv/array_list_engine_top.sv
sv/alst_checker.sv
bench/array_list_engine_top_test.sv
